### sv/cda_pkg.sv
// Package for the compensated double accumulator.
// Payload structs, command codes, queue entry and adder request types.
// No dependencies.
`default_nettype none
package cda_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_MERGE = 2'd2;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] POS_ZERO  = 64'h0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // adder pipeline depth, used by assertions
    localparam int ADD_LATENCY = 4;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] value;
        logic [63:0] other_correction;
    } cda_in_t;

    typedef struct packed {
        logic [63:0] sum_out;
        logic [63:0] correction_out;
    } cda_out_t;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_MERGE = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic [63:0] other_correction;
    } cda_op_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] a;
        logic [63:0] b;
    } cda_add_req_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] result;
    } cda_add_rsp_t;

    function automatic logic is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

endpackage
`default_nettype wire

### sv/cda_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on cda_pkg.
`default_nettype none
module cda_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cda_pkg::cda_in_t s_data,
    output logic                  q_valid,
    output cda_pkg::cda_op_t      q_op,
    input  wire logic             q_pop
);

    cda_pkg::cda_op_t                 mem_reg [cda_pkg::QUEUE_DEPTH];
    logic [cda_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cda_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cda_pkg::QCNT_W-1:0]       count_reg, count_next;
    cda_pkg::cda_op_t                 op_in;
    logic                             push, pop;

    always_comb begin
        op_in.value            = s_data.value;
        op_in.other_correction = s_data.other_correction;
        case (s_data.command)
            cda_pkg::CMD_CLEAR: op_in.kind = cda_pkg::KIND_CLEAR;
            cda_pkg::CMD_ADD:   op_in.kind = cda_pkg::KIND_ADD;
            cda_pkg::CMD_MERGE: op_in.kind = cda_pkg::KIND_MERGE;
            default:            op_in.kind = cda_pkg::KIND_NOP;
        endcase
    end

    assign s_ready = (count_reg != cda_pkg::QCNT_W'(cda_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == cda_pkg::QPTR_W'(cda_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == cda_pkg::QPTR_W'(cda_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + cda_pkg::QCNT_W'(push) - cda_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= op_in;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cda_pkg::QCNT_W'(cda_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointer mismatch");

endmodule
`default_nettype wire

### sv/cda_fpadd.sv
// Four-stage binary64 adder, round to nearest even, canonical NaN output.
// Stages: align, add, leading-zero count, normalize and round. Depends on cda_pkg.
`default_nettype none
module cda_fpadd (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cda_pkg::cda_add_req_t req,
    output cda_pkg::cda_add_rsp_t      rsp
);

    function automatic logic [5:0] lzc56(input logic [55:0] x);
        logic [5:0] n;
        n = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (x[i]) n = 6'(55 - i);
        end
        return n;
    endfunction

    // stage 1: unpack, order by magnitude, align smaller operand
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap;
    logic [63:0] big, sml;
    logic [10:0] eb_eff, es_eff, d;
    logic [55:0] mbig, msml, shifted, lost;

    logic        v1_reg, nan1_reg, inf1_reg, isgn1_reg, sgn1_reg, sub1_reg, zs1_reg;
    logic [10:0] e1_reg;
    logic [55:0] mb1_reg, ms1_reg;
    logic        nan1_next, inf1_next, isgn1_next, zs1_next;
    logic [55:0] ms1_next;

    always_comb begin
        sa     = req.a[63];
        sb     = req.b[63];
        a_nan  = cda_pkg::is_nan(req.a);
        b_nan  = cda_pkg::is_nan(req.b);
        a_inf  = (req.a[62:0] == 63'h7FF0_0000_0000_0000);
        b_inf  = (req.b[62:0] == 63'h7FF0_0000_0000_0000);
        swap   = req.b[62:0] > req.a[62:0];
        big    = swap ? req.b : req.a;
        sml    = swap ? req.a : req.b;
        eb_eff = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es_eff = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
        d      = eb_eff - es_eff;
        mbig   = {big[62:52] != 11'd0, big[51:0], 3'b000};
        msml   = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
        shifted = msml >> d[5:0];
        lost    = msml & ~({56{1'b1}} << d[5:0]);
        if (d >= 11'd56) begin
            ms1_next = {55'd0, |msml};
        end else begin
            ms1_next = shifted | {55'd0, |lost};
        end
        nan1_next  = a_nan || b_nan || (a_inf && b_inf && (sa != sb));
        inf1_next  = a_inf || b_inf;
        isgn1_next = a_inf ? sa : sb;
        zs1_next   = sa & sb;
    end

    // stage 2: add or subtract magnitudes
    logic        v2_reg, nan2_reg, inf2_reg, isgn2_reg, sgn2_reg, zs2_reg;
    logic [10:0] e2_reg;
    logic [56:0] m2_reg, m2_next;

    assign m2_next = sub1_reg ? ({1'b0, mb1_reg} - {1'b0, ms1_reg})
                              : ({1'b0, mb1_reg} + {1'b0, ms1_reg});

    // stage 3: fold carry-out, find the normalizing shift
    logic        v3_reg, nan3_reg, inf3_reg, isgn3_reg, sgn3_reg, zs3_reg, zero3_reg;
    logic [55:0] m3_reg, m3_next;
    logic [11:0] e3_reg, e3_next, lim;
    logic [5:0]  sh3_reg, sh3_next, lz;

    always_comb begin
        lz  = lzc56(m2_reg[55:0]);
        lim = {1'b0, e2_reg} - 12'd1;
        if (m2_reg[56]) begin
            m3_next  = {m2_reg[56:2], m2_reg[1] | m2_reg[0]};
            e3_next  = {1'b0, e2_reg} + 12'd1;
            sh3_next = 6'd0;
        end else begin
            m3_next  = m2_reg[55:0];
            e3_next  = {1'b0, e2_reg};
            sh3_next = ({6'd0, lz} < lim) ? lz : lim[5:0];
        end
    end

    // stage 4: shift, round, pack
    logic [55:0] sm;
    logic [11:0] ee;
    logic        inc;
    logic [62:0] packed_mag;
    logic [63:0] res_next;
    logic        v4_reg;
    logic [63:0] res4_reg;

    always_comb begin
        sm  = m3_reg << sh3_reg;
        ee  = sm[55] ? (e3_reg - {6'd0, sh3_reg}) : 12'd0;
        inc = sm[2] & (sm[1] | sm[0] | sm[3]);
        packed_mag = {ee[10:0], sm[54:3]} + 63'(inc);
        if (nan3_reg) begin
            res_next = cda_pkg::CANON_NAN;
        end else if (inf3_reg) begin
            res_next = {isgn3_reg, 11'h7FF, 52'd0};
        end else if (zero3_reg) begin
            res_next = {zs3_reg, 63'd0};
        end else if (ee >= 12'd2047) begin
            res_next = {sgn3_reg, 11'h7FF, 52'd0};
        end else begin
            res_next = {sgn3_reg, packed_mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        nan1_reg  <= nan1_next;
        inf1_reg  <= inf1_next;
        isgn1_reg <= isgn1_next;
        sgn1_reg  <= big[63];
        sub1_reg  <= sa ^ sb;
        zs1_reg   <= zs1_next;
        e1_reg    <= eb_eff;
        mb1_reg   <= mbig;
        ms1_reg   <= ms1_next;

        nan2_reg  <= nan1_reg;
        inf2_reg  <= inf1_reg;
        isgn2_reg <= isgn1_reg;
        sgn2_reg  <= sgn1_reg;
        zs2_reg   <= zs1_reg;
        e2_reg    <= e1_reg;
        m2_reg    <= m2_next;

        nan3_reg  <= nan2_reg;
        inf3_reg  <= inf2_reg;
        isgn3_reg <= isgn2_reg;
        sgn3_reg  <= sgn2_reg;
        zs3_reg   <= zs2_reg;
        zero3_reg <= (m2_reg == 57'd0);
        m3_reg    <= m3_next;
        e3_reg    <= e3_next;
        sh3_reg   <= sh3_next;

        res4_reg  <= res_next;
    end

    assign rsp.valid  = v4_reg;
    assign rsp.result = res4_reg;

endmodule
`default_nettype wire

### sv/cda_back.sv
// Back end: runs queued commands through the shared adder, holds the
// running sum and correction, and owns the result register. Depends on cda_pkg.
`default_nettype none
module cda_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire cda_pkg::cda_op_t      q_op,
    output logic                       q_pop,
    output cda_pkg::cda_add_req_t      add_req,
    input  wire cda_pkg::cda_add_rsp_t add_rsp,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output cda_pkg::cda_out_t          m_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_DIFF = 6'b000100,
        ST_LOST = 6'b001000,
        ST_CORR = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic              busy_reg, busy_next;
    logic              pend_reg, pend_next;
    logic              big_reg, big_next;
    logic [63:0]       sum_reg, sum_next;
    logic [63:0]       corr_reg, corr_next;
    logic [63:0]       opnd_reg, opnd_next;
    logic [63:0]       t_reg, t_next;
    logic [63:0]       lost_reg, lost_next;
    logic              out_valid_reg, out_valid_next;
    cda_pkg::cda_out_t out_reg, out_next;
    logic              out_free, sum_bigger;

    assign out_free = !out_valid_reg || m_ready;
    // NaN on either side makes the magnitude test false
    assign sum_bigger = !cda_pkg::is_nan(sum_reg) && !cda_pkg::is_nan(opnd_reg)
                     && (sum_reg[62:0] > opnd_reg[62:0]);

    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        big_next       = big_reg;
        sum_next       = sum_reg;
        corr_next      = corr_reg;
        opnd_next      = opnd_reg;
        t_next         = t_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        add_req.valid  = 1'b0;
        add_req.a      = sum_reg;
        add_req.b      = opnd_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_op.kind) inside
                        cda_pkg::KIND_CLEAR, cda_pkg::KIND_NOP: begin
                            if (out_free) begin
                                if (q_op.kind == cda_pkg::KIND_CLEAR) begin
                                    sum_next  = cda_pkg::POS_ZERO;
                                    corr_next = cda_pkg::POS_ZERO;
                                end
                                out_next.sum_out        = sum_next;
                                out_next.correction_out = corr_next;
                                out_valid_next = 1'b1;
                                q_pop          = 1'b1;
                            end
                        end
                        cda_pkg::KIND_MERGE: begin
                            opnd_next  = q_op.other_correction;
                            pend_next  = 1'b1;
                            state_next = ST_SUM;
                        end
                        default: begin
                            opnd_next  = q_op.value;
                            pend_next  = 1'b0;
                            state_next = ST_SUM;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                add_req.a = sum_reg;
                add_req.b = opnd_reg;
                if (!busy_reg) begin
                    add_req.valid = 1'b1;
                    busy_next     = 1'b1;
                    big_next      = sum_bigger;
                end else if (add_rsp.valid) begin
                    t_next     = add_rsp.result;
                    busy_next  = 1'b0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                add_req.a = big_reg ? sum_reg : opnd_reg;
                add_req.b = {~t_reg[63], t_reg[62:0]};
                if (!busy_reg) begin
                    add_req.valid = 1'b1;
                    busy_next     = 1'b1;
                end else if (add_rsp.valid) begin
                    lost_next  = add_rsp.result;
                    busy_next  = 1'b0;
                    state_next = ST_LOST;
                end
            end
            ST_LOST: begin
                add_req.a = lost_reg;
                add_req.b = big_reg ? opnd_reg : sum_reg;
                if (!busy_reg) begin
                    add_req.valid = 1'b1;
                    busy_next     = 1'b1;
                end else if (add_rsp.valid) begin
                    lost_next  = add_rsp.result;
                    busy_next  = 1'b0;
                    state_next = ST_CORR;
                end
            end
            ST_CORR: begin
                add_req.a = corr_reg;
                add_req.b = lost_reg;
                if (!busy_reg) begin
                    add_req.valid = 1'b1;
                    busy_next     = 1'b1;
                end else if (add_rsp.valid) begin
                    sum_next  = t_reg;
                    corr_next = add_rsp.result;
                    busy_next = 1'b0;
                    if (pend_reg) begin
                        // merge: the other sum follows its correction
                        opnd_next  = q_op.value;
                        pend_next  = 1'b0;
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_next.sum_out        = sum_reg;
                    out_next.correction_out = corr_reg;
                    out_valid_next = 1'b1;
                    q_pop          = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= cda_pkg::POS_ZERO;
            corr_reg      <= cda_pkg::POS_ZERO;
        end else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            corr_reg      <= corr_next;
        end
    end

    always_ff @(posedge aclk) begin
        big_reg  <= big_next;
        opnd_reg <= opnd_next;
        t_reg    <= t_next;
        lost_reg <= lost_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_rsp_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        add_rsp.valid |-> busy_reg)
        else $error("adder response with no request outstanding");
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        add_req.valid |-> ##(cda_pkg::ADD_LATENCY) add_rsp.valid)
        else $error("adder response missing");
    a_pop_state: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (out_free && (state_reg == ST_IDLE || state_reg == ST_DONE)))
        else $error("queue pop outside idle or done");

endmodule
`default_nettype wire

### sv/compensated_double_accumulator.sv
// Compensated (Kahan-Neumaier) binary64 accumulator, top level.
// Input channel s_*: one command per transfer (clear, add value, merge another
// accumulator given as value = its sum and other_correction = its correction;
// command 3 changes nothing). Result channel m_*: one transfer per command
// with the sum and correction after it; NaN results read 0x7FF8000000000000.
// A two-entry command queue decouples input from execution, so s_ready stays
// high while the queue has room; the result sits in an output register and the
// back end keeps working until it must write a new result into a full one.
// Each add is four dependent passes through one four-stage double adder; a
// merge is eight, its correction first and then its sum, and a clear or unused
// command needs no adder pass. The back end takes up a new command only after
// the last one has written its result, so sustained throughput is set by the adder loop.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result
// and sets sum and correction to positive zero. A stalled receiver holds the
// result; once the queue fills, s_ready drops.
// Depends on cda_pkg, cda_front, cda_fpadd, cda_back.
`default_nettype none
module compensated_double_accumulator (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cda_pkg::cda_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cda_pkg::cda_out_t      m_data
);

    logic                  q_valid, q_pop;
    cda_pkg::cda_op_t      q_op;
    cda_pkg::cda_add_req_t add_req;
    cda_pkg::cda_add_rsp_t add_rsp;

    cda_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    cda_fpadd u_fpadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (add_req),
        .rsp     (add_rsp)
    );

    cda_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .add_req (add_req),
        .add_rsp (add_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
